[design/bbicl_pkg.sv]
// ----------------------------------------------------------------------------
// bbicl_pkg
// Types and constants shared by the charger current loop modules.
// ----------------------------------------------------------------------------
package bbicl_pkg;

  localparam int FRACTION_BITS = 6;
  localparam int GAIN_SHIFT    = 2;

  localparam int SAMPLE_W    = 16;
  localparam int PERIOD_W    = 14;
  localparam int DRIVE_W     = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int ACC_W       = DRIVE_W + FRACTION_BITS;
  localparam int ERR_W       = SAMPLE_W + 1;
  localparam int SUM_W       = ACC_W + 2;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_ENABLE  = 2'd1,
    ACT_DISABLE = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF = 2'd0,
    CFG_PERIOD = 2'd1,
    CFG_MAXDRV = 2'd2
  } cfg_idx_t;

  localparam logic [SAMPLE_W-1:0] CUTOFF_RST = 16'd65535;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 14'd1023;
  localparam logic [DRIVE_W-1:0]  MAXDRV_RST = 15'd1637;

  typedef struct packed {
    logic [SAMPLE_W-1:0] cutoff_code;
    logic [PERIOD_W-1:0] pwm_period;
    logic [DRIVE_W-1:0]  max_drive;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [SAMPLE_W-1:0] current_sample;
    logic [SAMPLE_W-1:0] vout_sample;
    logic [SAMPLE_W-1:0] target_current;
    logic [SAMPLE_W-1:0] supply_level;
    logic [SAMPLE_W-1:0] output_level;
  } item_t;

  typedef struct packed {
    logic                drive_updated;
    logic [PERIOD_W-1:0] buck_duty;
    logic                buck_full_on;
    logic [DRIVE_W-1:0]  boost_duty;
    logic                running;
    logic                tripped;
  } result_t;

endpackage

[design/bbicl_calc.sv]
// ----------------------------------------------------------------------------
// bbicl_calc
// Per item: integral update, clamp, buck/boost split, enable/disable, trip.
// ----------------------------------------------------------------------------
module bbicl_calc (
  input  bbicl_pkg::item_t               item,
  input  bbicl_pkg::cfg_t                cfg,
  input  logic [bbicl_pkg::ACC_W-1:0]    acc,
  input  logic                           running,
  output logic [bbicl_pkg::ACC_W-1:0]    acc_nxt,
  output logic                           running_nxt,
  output bbicl_pkg::result_t             result
);

  logic signed [bbicl_pkg::ERR_W-1:0]   err;
  logic signed [bbicl_pkg::SUM_W-1:0]   err_scaled;
  logic signed [bbicl_pkg::SUM_W-1:0]   sum;
  logic        [bbicl_pkg::ACC_W-1:0]   ceiling;
  logic        [bbicl_pkg::ACC_W-1:0]   preset;
  logic        [bbicl_pkg::ACC_W-1:0]   acc_clamped;
  logic        [bbicl_pkg::DRIVE_W-1:0] drive_raw;
  logic        [bbicl_pkg::DRIVE_W-1:0] drive;
  logic        [bbicl_pkg::DRIVE_W-1:0] period_ext;
  bbicl_pkg::result_t                   res_off;
  bbicl_pkg::result_t                   res_on;

  always_comb begin
    err        = $signed({1'b0, item.target_current}) - $signed({1'b0, item.current_sample});
    err_scaled = bbicl_pkg::SUM_W'(err) <<< bbicl_pkg::GAIN_SHIFT;
    sum        = $signed({2'b00, acc}) + err_scaled;
    ceiling    = bbicl_pkg::ACC_W'(cfg.max_drive) << bbicl_pkg::FRACTION_BITS;
    preset     = bbicl_pkg::ACC_W'(cfg.pwm_period) << bbicl_pkg::FRACTION_BITS;

    if (sum[bbicl_pkg::SUM_W-1]) begin
      acc_clamped = '0;
    end else if (sum > $signed({2'b00, ceiling})) begin
      acc_clamped = ceiling;
    end else begin
      acc_clamped = sum[bbicl_pkg::ACC_W-1:0];
    end

    drive_raw  = acc_clamped[bbicl_pkg::ACC_W-1:bbicl_pkg::FRACTION_BITS];
    drive      = (drive_raw > cfg.max_drive) ? cfg.max_drive : drive_raw;
    period_ext = bbicl_pkg::DRIVE_W'(cfg.pwm_period);

    res_on.drive_updated = 1'b1;
    res_on.running       = 1'b1;
    res_on.tripped       = 1'b0;
    if (drive <= period_ext) begin
      res_on.buck_duty    = drive[bbicl_pkg::PERIOD_W-1:0];
      res_on.buck_full_on = 1'b0;
      res_on.boost_duty   = '0;
    end else begin
      res_on.buck_duty    = cfg.pwm_period;
      res_on.buck_full_on = 1'b1;
      res_on.boost_duty   = drive - period_ext;
    end
  end

  always_comb begin
    acc_nxt     = acc;
    running_nxt = running;
    res_off     = '0;
    unique case (bbicl_pkg::action_t'(item.action))
      bbicl_pkg::ACT_ENABLE: begin
        acc_nxt     = (item.output_level > item.supply_level) ? preset : '0;
        running_nxt = 1'b1;
      end
      bbicl_pkg::ACT_TICK: begin
        if (running && (item.vout_sample >= cfg.cutoff_code)) begin
          running_nxt     = 1'b0;
          res_off.tripped = 1'b1;
        end else if (running) begin
          acc_nxt = acc_clamped;
        end
      end
      default: begin
        running_nxt = 1'b0;
      end
    endcase
    res_off.running = running_nxt;
    result = (bbicl_pkg::action_t'(item.action) == bbicl_pkg::ACT_TICK && running
              && !(item.vout_sample >= cfg.cutoff_code)) ? res_on : res_off;
  end

endmodule

[design/buck_boost_integral_current_loop_top.sv]
// ----------------------------------------------------------------------------
// buck_boost_integral_current_loop_top
// Charger current loop: integral controller driving buck/boost PWM compares.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   action, samples, levels
//   out_     output     out_valid/out_stall drive fields, running, tripped
//   cfg_     input      cfg_valid/cfg_ready index, data (always ready)
//
// one item per cycle unless stalled; out_valid follows the input register
// the accumulator is updated in the compute stage, so items follow back to back
// rst_n clears the loop state, the valid flags and the config to defaults
// a stall on out_ holds the result register and backs up into in_stall
// ----------------------------------------------------------------------------
module buck_boost_integral_current_loop_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_action,
  input  logic [bbicl_pkg::SAMPLE_W-1:0]       in_current_sample,
  input  logic [bbicl_pkg::SAMPLE_W-1:0]       in_vout_sample,
  input  logic [bbicl_pkg::SAMPLE_W-1:0]       in_target_current,
  input  logic [bbicl_pkg::SAMPLE_W-1:0]       in_supply_level,
  input  logic [bbicl_pkg::SAMPLE_W-1:0]       in_output_level,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_drive_updated,
  output logic [bbicl_pkg::PERIOD_W-1:0]       out_buck_duty,
  output logic                                 out_buck_full_on,
  output logic [bbicl_pkg::DRIVE_W-1:0]        out_boost_duty,
  output logic                                 out_running,
  output logic                                 out_tripped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bbicl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bbicl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  bbicl_pkg::cfg_t                   cfg_r;
  bbicl_pkg::item_t                  item_r;
  logic                              item_valid_r;
  logic [bbicl_pkg::ACC_W-1:0]       acc_r;
  logic [bbicl_pkg::ACC_W-1:0]       acc_nxt;
  logic                              running_r;
  logic                              running_nxt;
  bbicl_pkg::result_t                result_nxt;
  bbicl_pkg::result_t                result_r;
  logic                              out_valid_r;
  logic                              advance;
  logic                              in_take;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = item_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff_code <= bbicl_pkg::CUTOFF_RST;
      cfg_r.pwm_period  <= bbicl_pkg::PERIOD_RST;
      cfg_r.max_drive   <= bbicl_pkg::MAXDRV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bbicl_pkg::cfg_idx_t'(cfg_index))
        bbicl_pkg::CFG_CUTOFF: cfg_r.cutoff_code <= cfg_data;
        bbicl_pkg::CFG_PERIOD: cfg_r.pwm_period  <= cfg_data[bbicl_pkg::PERIOD_W-1:0];
        bbicl_pkg::CFG_MAXDRV: cfg_r.max_drive   <= cfg_data[bbicl_pkg::DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action         <= in_action;
      item_r.current_sample <= in_current_sample;
      item_r.vout_sample    <= in_vout_sample;
      item_r.target_current <= in_target_current;
      item_r.supply_level   <= in_supply_level;
      item_r.output_level   <= in_output_level;
    end
  end

  bbicl_calc u_calc (
    .item        (item_r),
    .cfg         (cfg_r),
    .acc         (acc_r),
    .running     (running_r),
    .acc_nxt     (acc_nxt),
    .running_nxt (running_nxt),
    .result      (result_nxt)
  );

  // loop state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
      if (item_valid_r) begin
        acc_r     <= acc_nxt;
        running_r <= running_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_updated = result_r.drive_updated;
  assign out_buck_duty     = result_r.buck_duty;
  assign out_buck_full_on  = result_r.buck_full_on;
  assign out_boost_duty    = result_r.boost_duty;
  assign out_running       = result_r.running;
  assign out_tripped       = result_r.tripped;

  a_trip_stops : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.tripped |-> !result_r.running && !result_r.drive_updated)
    else $error("trip result with loop still running");

  a_update_running : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.drive_updated |-> result_r.running)
    else $error("drive update while loop stopped");

  a_off_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !result_r.drive_updated |->
      result_r.buck_duty == '0 && result_r.boost_duty == '0 && !result_r.buck_full_on)
    else $error("drives not off without update");

  a_state_matches : assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance && item_valid_r) |-> result_r.running == running_r)
    else $error("result running flag differs from loop state");

endmodule
